@@ rtl/vector_elementwise_alu_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the vector element-wise ALU
// Immediate-implication and next-cycle-implication checks on one clock.
// ---------------------------------------------------------------------------
`ifndef VECTOR_ELEMENTWISE_ALU_MACROS_SVH
`define VECTOR_ELEMENTWISE_ALU_MACROS_SVH

// Check cons in the same cycle as ante.
`define VEA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define VEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/vea_pkg.sv @@
// ---------------------------------------------------------------------------
// vea_pkg
// Shared constants, codes and the per-lane pipeline record.
// ---------------------------------------------------------------------------
package vea_pkg;

  localparam int NUM_LANES_MAX = 4;
  localparam int LANES         = 4;   // active lanes, 2..4
  localparam int FRAC_BITS     = 16;  // fraction bits, 0..30
  localparam int Q_W           = 32;
  localparam int CMD_W         = 3;
  localparam int DIV_STEPS     = 32;  // one quotient bit per cell
  // input register, prep stage, divider cells, output register
  localparam int STAGES        = DIV_STEPS + 3;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [Q_W-1:0] q_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SAT,
    ST_DZ
  } status_t;

  // One lane's work in flight. acc holds the add/sub result, the raw
  // product, or the divider remainder (high half) and dividend/quotient
  // bits (low half).
  typedef struct packed {
    op_t              op;
    logic [2*Q_W-1:0] acc;
    logic [Q_W-1:0]   dv;
    logic             neg;
    logic             ovf;
    logic             dz;
    logic             a_neg;
    logic             a_zero;
    logic             sat;
  } lane_t;

endpackage

@@ rtl/vea_if.sv @@
// ---------------------------------------------------------------------------
// vea_if
// Valid/ready channel interfaces for request and response items.
// ---------------------------------------------------------------------------
interface vea_req_if import vea_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  q_t               a_x;
  q_t               a_y;
  q_t               a_z;
  q_t               a_w;
  q_t               b_x;
  q_t               b_y;
  q_t               b_z;
  q_t               b_w;
  q_t               scalar_value;

  modport source (output valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  scalar_value, input ready);
  modport sink (input valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                scalar_value, output ready);
endinterface

interface vea_rsp_if import vea_pkg::*; ();
  logic       valid;
  logic       ready;
  q_t         r_x;
  q_t         r_y;
  q_t         r_z;
  q_t         r_w;
  logic [1:0] status;

  modport source (output valid, r_x, r_y, r_z, r_w, status, input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, status, output ready);
endinterface

@@ rtl/vector_elementwise_alu.sv @@
// ---------------------------------------------------------------------------
// vector_elementwise_alu
// Four-lane element-wise Q16.16 add, subtract, multiply and divide.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one item: a 3-bit command (op in bits 1:0, scalar mode in
//   bit 2), vectors a and b, and a scalar that replaces b in scalar mode.
//   rsp carries the four lane results and a status code (ok, saturated,
//   divided by zero; divide by zero wins).
// Timing:
//   Every item runs the same 35-stage pipeline: input register, prep
//   stage (adder, 32x32 multiplier, divider setup), 32 divider cells that
//   each retire one quotient bit, and the output register. One item is
//   accepted per cycle while the output is not stalled; the 32-cell
//   divider chain sets the latency.
// Reset:
//   rst (synchronous) clears all stage valid bits; items in flight drop.
// Stall:
//   When rsp holds a result that is not taken, the whole chain holds and
//   req.ready falls; it rises again in the cycle the result is taken.
// ---------------------------------------------------------------------------
`include "vector_elementwise_alu_macros.svh"

module vector_elementwise_alu import vea_pkg::*; (
  input logic  clk,
  input logic  rst,
  vea_req_if.sink   req,
  vea_rsp_if.source rsp
);

  logic [STAGES-1:0] vld;
  logic              adv;

  op_t op_a;
  q_t  a_in [NUM_LANES_MAX];
  q_t  b_in [NUM_LANES_MAX];
  q_t  a_q  [NUM_LANES_MAX];
  q_t  b_q  [NUM_LANES_MAX];

  q_t   r_lane   [NUM_LANES_MAX];
  logic sat_lane [NUM_LANES_MAX];
  logic dz_lane  [NUM_LANES_MAX];
  logic any_sat;
  logic any_dz;

  // Whole chain advances together whenever the output slot is free or its result is taken.
  assign adv       = !vld[STAGES-1] || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], req.valid};
    end
  end

  always_comb begin
    a_in[0] = req.a_x;
    a_in[1] = req.a_y;
    a_in[2] = req.a_z;
    a_in[3] = req.a_w;
    b_in[0] = req.b_x;
    b_in[1] = req.b_y;
    b_in[2] = req.b_z;
    b_in[3] = req.b_w;
  end

  // Input register: broadcast the scalar in scalar mode.
  always_ff @(posedge clk) begin
    if (adv) begin
      op_a <= op_t'(req.command[1:0]);
      for (int l = 0; l < NUM_LANES_MAX; l++) begin
        a_q[l] <= a_in[l];
        b_q[l] <= req.command[2] ? req.scalar_value : b_in[l];
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES_MAX; l++) begin : g_lane
    if (l < LANES) begin : g_on
      lane_t chain [DIV_STEPS+1];

      vea_prep u_prep (
        .clk  (clk),
        .en   (adv),
        .op   (op_a),
        .a    (a_q[l]),
        .b    (b_q[l]),
        .lane (chain[0])
      );

      for (genvar s = 0; s < DIV_STEPS; s++) begin : g_cell
        vea_div_cell u_cell (
          .clk  (clk),
          .en   (adv),
          .din  (chain[s]),
          .dout (chain[s+1])
        );
      end

      vea_finish u_finish (
        .lane (chain[DIV_STEPS]),
        .r    (r_lane[l]),
        .sat  (sat_lane[l]),
        .dz   (dz_lane[l])
      );
    end else begin : g_off
      // unused lane: zero result, no part in the status
      assign r_lane[l]   = '0;
      assign sat_lane[l] = 1'b0;
      assign dz_lane[l]  = 1'b0;
    end
  end

  always_comb begin
    any_sat = 1'b0;
    any_dz  = 1'b0;
    for (int l = 0; l < NUM_LANES_MAX; l++) begin
      any_sat = any_sat | sat_lane[l];
      any_dz  = any_dz | dz_lane[l];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.r_x    <= r_lane[0];
      rsp.r_y    <= r_lane[1];
      rsp.r_z    <= r_lane[2];
      rsp.r_w    <= r_lane[3];
      rsp.status <= any_dz ? ST_DZ : (any_sat ? ST_SAT : ST_OK);
    end
  end

  `VEA_ASSERT_NOW(a_ready_when_free, clk, rst, !rsp.valid, req.ready, "input stalled with free output")
  `VEA_ASSERT_NEXT(a_accept_enters, clk, rst, req.valid && req.ready, vld[0], "accepted item lost")
  `VEA_ASSERT_NEXT(a_tail_holds, clk, rst, vld[STAGES-2] && !req.ready, vld[STAGES-2], "stalled item dropped")
  `VEA_ASSERT_NOW(a_status_code, clk, rst, rsp.valid, rsp.status == ST_OK || rsp.status == ST_SAT || rsp.status == ST_DZ, "bad status code")

endmodule

@@ rtl/vea_prep.sv @@
// ---------------------------------------------------------------------------
// vea_prep
// First lane stage: add/sub with saturation, raw product, divider setup.
// ---------------------------------------------------------------------------
module vea_prep import vea_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  op_t   op,
  input  q_t    a,
  input  q_t    b,
  output lane_t lane
);

  logic signed [Q_W:0]     sum;
  logic signed [2*Q_W-1:0] prod;
  logic [Q_W-1:0]          mag_a;
  logic [Q_W-1:0]          mag_b;
  logic [2*Q_W-1:0]        num;
  logic                    sum_ovf;
  lane_t                   nx;

  always_comb begin
    if (op == OP_SUB) begin
      sum = {a[Q_W-1], a} - {b[Q_W-1], b};
    end else begin
      sum = {a[Q_W-1], a} + {b[Q_W-1], b};
    end
    sum_ovf = sum[Q_W] != sum[Q_W-1];
    prod    = a * b;
    mag_a   = a[Q_W-1] ? (~a + 1'b1) : a;
    mag_b   = b[Q_W-1] ? (~b + 1'b1) : b;
    // scaled dividend; high half starts as the remainder
    num     = {{Q_W{1'b0}}, mag_a} << FRAC_BITS;

    nx        = '0;
    nx.op     = op;
    nx.dv     = mag_b;
    nx.neg    = a[Q_W-1] ^ b[Q_W-1];
    nx.ovf    = num[2*Q_W-1:Q_W] >= mag_b;
    nx.dz     = b == '0;
    nx.a_neg  = a[Q_W-1];
    nx.a_zero = a == '0;
    case (op)
      OP_ADD, OP_SUB: begin
        nx.sat = sum_ovf;
        if (sum_ovf) begin
          nx.acc = {{Q_W{1'b0}}, (sum[Q_W] ? Q_MIN : Q_MAX)};
        end else begin
          nx.acc = {{Q_W{1'b0}}, sum[Q_W-1:0]};
        end
      end
      OP_MUL: begin
        nx.acc = prod;
      end
      default: begin
        nx.acc = num;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane <= nx;
    end
  end

endmodule

@@ rtl/vea_div_cell.sv @@
// ---------------------------------------------------------------------------
// vea_div_cell
// One restoring-division step for one lane; other ops pass through.
// ---------------------------------------------------------------------------
module vea_div_cell import vea_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  lane_t din,
  output lane_t dout
);

  logic [Q_W:0] trial;
  logic [Q_W:0] diff;
  logic         ge;
  lane_t        nx;

  always_comb begin
    // shift the next dividend bit into the remainder
    trial = {din.acc[2*Q_W-1:Q_W], din.acc[Q_W-1]};
    diff  = trial - {1'b0, din.dv};
    ge    = trial >= {1'b0, din.dv};
    nx    = din;
    if (din.op == OP_DIV) begin
      nx.acc = {(ge ? diff[Q_W-1:0] : trial[Q_W-1:0]), din.acc[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nx;
    end
  end

endmodule

@@ rtl/vea_finish.sv @@
// ---------------------------------------------------------------------------
// vea_finish
// Last lane step: product scaling, quotient sign, saturation and flags.
// ---------------------------------------------------------------------------
module vea_finish import vea_pkg::*; (
  input  lane_t lane,
  output q_t    r,
  output logic  sat,
  output logic  dz
);

  logic signed [2*Q_W-1:0] sh;
  logic [Q_W-1:0]          q;

  always_comb begin
    sh  = $signed(lane.acc) >>> FRAC_BITS;
    q   = lane.acc[Q_W-1:0];
    r   = '0;
    sat = 1'b0;
    dz  = 1'b0;
    case (lane.op)
      OP_ADD, OP_SUB: begin
        r   = lane.acc[Q_W-1:0];
        sat = lane.sat;
      end
      OP_MUL: begin
        if ((&sh[2*Q_W-1:Q_W-1]) || !(|sh[2*Q_W-1:Q_W-1])) begin
          r = sh[Q_W-1:0];
        end else begin
          sat = 1'b1;
          r   = sh[2*Q_W-1] ? Q_MIN : Q_MAX;
        end
      end
      default: begin
        if (lane.dz) begin
          dz = 1'b1;
          r  = lane.a_zero ? '0 : (lane.a_neg ? Q_MIN : Q_MAX);
        end else if (lane.neg) begin
          if (lane.ovf || q > Q_MIN) begin
            sat = 1'b1;
            r   = Q_MIN;
          end else begin
            r = ~q + 1'b1;
          end
        end else begin
          if (lane.ovf || q[Q_W-1]) begin
            sat = 1'b1;
            r   = Q_MAX;
          end else begin
            r = q;
          end
        end
      end
    endcase
  end

endmodule

@@ verif/vector_elementwise_alu_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_elementwise_alu_checker
// Watches the request and response channels, predicts each response from
// the accepted request and compares it lane by lane with the block's output.
// ---------------------------------------------------------------------------
module vector_elementwise_alu_checker import vea_pkg::*; (
  input  logic clk,
  input  logic rst,
  vea_req_if.sink  req,
  vea_rsp_if.sink  rsp,
  output int       fail_count,
  output int       pending_count
);

  typedef struct packed {
    q_t         r_x;
    q_t         r_y;
    q_t         r_z;
    q_t         r_w;
    logic [1:0] status;
  } vec_result_t;

  vec_result_t expected_results[$];
  int          mismatch_count;

  function automatic q_t clamp_q(input logic signed [65:0] v, inout logic sat);
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      return q_t'(Q_MAX);
    end
    if (v < -66'sd2147483648) begin
      sat = 1'b1;
      return q_t'(Q_MIN);
    end
    return q_t'(v[31:0]);
  endfunction

  function automatic q_t lane_result(input op_t op, input q_t a, input q_t b,
                                     inout logic sat, inout logic dz);
    logic signed [65:0] wide_a;
    logic signed [65:0] wide_b;
    logic signed [65:0] prod;
    wide_a = 66'(a);
    wide_b = 66'(b);
    case (op)
      OP_ADD: return clamp_q(wide_a + wide_b, sat);
      OP_SUB: return clamp_q(wide_a - wide_b, sat);
      OP_MUL: begin
        prod = wide_a * wide_b;
        return clamp_q(prod >>> FRAC_BITS, sat);
      end
      default: begin
        if (b == 0) begin
          dz = 1'b1;
          if (a > 0) return q_t'(Q_MAX);
          if (a < 0) return q_t'(Q_MIN);
          return '0;
        end
        // SystemVerilog signed division truncates toward zero
        return clamp_q((wide_a <<< FRAC_BITS) / wide_b, sat);
      end
    endcase
  endfunction

  function automatic vec_result_t compute_elementwise(input logic [CMD_W-1:0] cmd,
                                                      input q_t a[4], input q_t b[4],
                                                      input q_t sc);
    vec_result_t res;
    q_t          lane_out[4];
    logic        sat;
    logic        dz;
    sat = 1'b0;
    dz  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      lane_out[i] = '0;
      if (i < LANES)
        lane_out[i] = lane_result(op_t'(cmd[1:0]), a[i], cmd[2] ? sc : b[i], sat, dz);
    end
    res.r_x = lane_out[0];
    res.r_y = lane_out[1];
    res.r_z = lane_out[2];
    res.r_w = lane_out[3];
    res.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input vec_result_t exp_r,
                                 input vec_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch %s: expected %h %h %h %h st %0d, got %h %h %h %h st %0d",
               $time, what, exp_r.r_x, exp_r.r_y, exp_r.r_z, exp_r.r_w, exp_r.status,
               got.r_x, got.r_y, got.r_z, got.r_w, got.status);
  endtask

  always @(posedge clk) begin
    vec_result_t got;
    vec_result_t exp_r;
    q_t          a_vec[4];
    q_t          b_vec[4];
    if (rst) begin
      expected_results.delete();
      mismatch_count = 0;
      pending_count  = 0;
    end else begin
      if (req.valid && req.ready) begin
        a_vec = '{req.a_x, req.a_y, req.a_z, req.a_w};
        b_vec = '{req.b_x, req.b_y, req.b_z, req.b_w};
        expected_results.push_back(
          compute_elementwise(req.command, a_vec, b_vec, req.scalar_value));
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.r_x, rsp.r_y, rsp.r_z, rsp.r_w, rsp.status};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.r_x !== exp_r.r_x) report_mismatch("r_x", exp_r, got);
          if (got.r_y !== exp_r.r_y) report_mismatch("r_y", exp_r, got);
          if (got.r_z !== exp_r.r_z) report_mismatch("r_z", exp_r, got);
          if (got.r_w !== exp_r.r_w) report_mismatch("r_w", exp_r, got);
          if (got.status !== exp_r.status) report_mismatch("status", exp_r, got);
        end
      end
      pending_count = expected_results.size();
    end
  end

  assign fail_count = mismatch_count;

endmodule

@@ verif/vector_elementwise_alu_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector_elementwise_alu_tb
// Drives directed and random vector requests with random gaps and response
// stalls, including one long hold-off, while the checker predicts results.
// ---------------------------------------------------------------------------
module vector_elementwise_alu_tb;
  import vea_pkg::*;

  localparam int   RANDOM_ITEMS = 488;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   DRAIN_CYCLES = STAGES + 10;
  localparam int   LONG_HOLD_AT = 50;
  localparam int   LONG_HOLD    = 120;
  localparam logic MODE_VEC     = 1'b0;
  localparam logic MODE_SCALAR  = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;

  vea_req_if req ();
  vea_rsp_if rsp ();

  vector_elementwise_alu dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  vector_elementwise_alu_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req.sink),
    .rsp           (rsp.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #2 clk = ~clk;

  // Stop a run that hangs.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("vector_elementwise_alu_tb: errors");
      $finish;
    end
  end

  function automatic q_t rand_q();
    int unsigned pick;
    pick = $urandom_range(9, 0);
    case (pick)
      0: return '0;
      1: return q_t'(Q_MAX);
      2: return q_t'(Q_MIN);
      3: return q_t'(32'hFFFF_FFFF);
      4, 5: return q_t'($urandom_range(32'h0004_0000, 0)) - q_t'(32'h0002_0000);
      6: return q_t'(32'($urandom_range(8, 0)) << FRAC_BITS);
      default: return q_t'($urandom());
    endcase
  endfunction

  // Offer one item after a random gap and hold it until accepted.
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input q_t ax, input q_t ay, input q_t az, input q_t aw,
                           input q_t bx, input q_t by, input q_t bz, input q_t bw,
                           input q_t sc);
    int gap;
    gap = $urandom_range(4, 0);
    req.valid = 1'b0;
    repeat (gap) @(negedge clk);
    req.command      = cmd;
    req.a_x          = ax;
    req.a_y          = ay;
    req.a_z          = az;
    req.a_w          = aw;
    req.b_x          = bx;
    req.b_y          = by;
    req.b_z          = bz;
    req.b_w          = bw;
    req.scalar_value = sc;
    req.valid        = 1'b1;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  initial begin : stim
    logic [CMD_W-1:0] cmd;
    req.valid        = 1'b0;
    req.command      = '0;
    req.a_x          = '0;
    req.a_y          = '0;
    req.a_z          = '0;
    req.a_w          = '0;
    req.b_x          = '0;
    req.b_y          = '0;
    req.b_z          = '0;
    req.b_w          = '0;
    req.scalar_value = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // add and subtract at the range ends
    send_item({MODE_VEC, OP_ADD}, Q_MAX, 1, -5, Q_MIN, 1, 2, 7, -1, 0);
    send_item({MODE_VEC, OP_SUB}, Q_MIN, Q_MAX, 0, 100, 1, -1, Q_MIN, 3, 0);
    // multiply with rounding toward minus infinity, then saturation
    send_item({MODE_VEC, OP_MUL}, 32'h0002_0000, 32'hFFFE_8000, 3, -3,
              32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 1, 0);
    send_item({MODE_VEC, OP_MUL}, Q_MAX, Q_MIN, Q_MIN, Q_MAX,
              Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0);
    // divide by zero for every dividend sign
    send_item({MODE_VEC, OP_DIV}, 5, -5, 0, Q_MIN, 0, 0, 0, 0, 7);
    send_item({MODE_VEC, OP_DIV}, Q_MIN, 32'h0003_0000, -7, 1,
              -1, 32'h0002_0000, 2, 3, 0);
    send_item({MODE_SCALAR, OP_DIV}, 1, -1, 0, 2, 5, 5, 5, 5, 0);
    send_item({MODE_SCALAR, OP_MUL}, 32'h0003_0000, -7, Q_MAX, Q_MIN,
              1, 2, 3, 4, 32'h0000_8000);
    send_item({MODE_SCALAR, OP_ADD}, 1, 2, 3, Q_MAX, 9, 9, 9, 9, 1);
    // quotient of exactly -2^31 and exactly 2^31, one past the maximum
    send_item({MODE_VEC, OP_DIV}, Q_MIN, 32'h4000_0000, -1, 32'hC000_0000,
              32'h0001_0000, 32'h0000_8000, Q_MAX, 32'h0000_8000, 0);
    send_item({MODE_SCALAR, OP_SUB}, 0, -1, 1, Q_MIN, 0, 0, 0, 0, Q_MIN);
    // divide by zero outranks saturation
    send_item({MODE_VEC, OP_DIV}, Q_MAX, 1, 1, 1, 1, 0, 32'h0001_0000, 2, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      cmd = CMD_W'($urandom_range(7, 0));
      send_item(cmd, rand_q(), rand_q(), rand_q(), rand_q(),
                rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
    end

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("vector_elementwise_alu_tb: clean");
    end else begin
      $display("vector_elementwise_alu_tb: errors");
    end
    $finish;
  end

  // Receiver: random wait before each result, one long hold-off.
  initial begin : recv
    int wait_cycles;
    int taken;
    taken     = 0;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == LONG_HOLD_AT) begin
        wait_cycles = LONG_HOLD;
      end else begin
        wait_cycles = $urandom_range(4, 0);
      end
      rsp.ready = 1'b0;
      repeat (wait_cycles) @(negedge clk);
      rsp.ready = 1'b1;
      do @(posedge clk); while (!rsp.valid);
      taken++;
      @(negedge clk);
    end
  end

endmodule
